// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, codes and the command/status types shared by the cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // store geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int OCC_W   = $clog2(ENTRIES + 1);

   // field widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   // operation codes
   typedef enum logic {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic lookup;
      logic execute;
   } dp_cmd_type;

   // datapath to controller (and checks)
   typedef struct packed {
      logic               out_free;
      logic [OCC_W-1:0]   occupancy;
      logic [ENTRIES-1:0] entry_valid;
   } dp_status_type;

endpackage

// ===== rtl/lkvc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one cache operation per item.
// ----------------------------------------------------------------------------
interface lkvc_req_if
   import lkvc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [KEY_W-1:0] key;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output operation, output key, output value, input ready);
   modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

// ===== rtl/lkvc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one cache result per item.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if
   import lkvc_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] read_value;
   logic                    evicted;

   modport source (output valid, output hit, output read_value, output evicted, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

// ===== rtl/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache controller
// Sequences accept, lookup and execute steps for one item at a time.
// ----------------------------------------------------------------------------
module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            // wait until the output register can take the result
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/lkvc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache datapath
// Entry storage, parallel key match, recency ranks and the output register.
// ----------------------------------------------------------------------------
module lkvc_datapath
   import lkvc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic                    req_operation,
   input  logic [KEY_W-1:0]        req_key,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    csr_write_enable,
   input  logic [CAP_W-1:0]        csr_write_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_evicted
);

   // configuration
   logic [CAP_W-1:0] cap_ff;
   logic [OCC_W-1:0] eff_cap;

   // entry storage
   logic [KEY_W-1:0]   keys_ff   [ENTRIES];
   logic [VAL_W-1:0]   values_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   rank_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_in [ENTRIES];
   logic [OCC_W-1:0]   occ_ff, occ_in;

   // captured request
   logic             req_op_ff;
   logic [KEY_W-1:0] req_key_ff;
   logic [VAL_W-1:0] req_value_ff;

   // lookup results
   logic               match_hit;
   logic [IDX_W-1:0]   match_idx;
   logic [ENTRIES-1:0] victim_oh;
   logic               evict_now;
   logic [ENTRIES-1:0] remaining;
   logic [IDX_W-1:0]   free_idx;

   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [IDX_W-1:0]   hit_rank_ff;
   logic               evict_ff;
   logic [ENTRIES-1:0] victim_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic               insert;

   // output register
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic             rsp_evicted_ff;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // zero counts as one, anything above the store size saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = OCC_W'(1);
      end else if (int'(cap_ff) > ENTRIES) begin
         eff_cap = OCC_W'(ENTRIES);
      end else begin
         eff_cap = OCC_W'(cap_ff);
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_op_ff    <= req_operation;
         req_key_ff   <= req_key;
         req_value_ff <= req_value;
      end
   end

   // parallel key compare
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && keys_ff[i] == req_key_ff) begin
            match_hit = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
   end

   // oldest valid entry holds rank occupancy-1
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim_oh[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_ff - OCC_W'(1));
      end
   end

   assign evict_now = (req_op_ff == OP_SET) && !match_hit && (occ_ff >= eff_cap)
                      && (occ_ff != '0);
   assign remaining = valid_ff & ~(evict_now ? victim_oh : '0);

   // lowest free slot after a possible eviction
   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!remaining[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // lookup register
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff      <= match_hit;
         hit_idx_ff  <= match_idx;
         hit_rank_ff <= rank_ff[match_idx];
         evict_ff    <= evict_now;
         victim_ff   <= evict_now ? victim_oh : '0;
         slot_ff     <= free_idx;
      end
   end

   assign insert = (req_op_ff == OP_SET) && !hit_ff;

   // next valid bits, ranks and occupancy
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.execute) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (insert && slot_ff == IDX_W'(i)) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (victim_ff[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               if (hit_ff && hit_idx_ff == IDX_W'(i)) begin
                  rank_in[i] = '0;
               end else if (insert || (hit_ff && rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
         end
         if (insert && !evict_ff) begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end
   end

   // control state of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // key and value writes
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.execute && insert && slot_ff == IDX_W'(i)) begin
            keys_ff[i]   <= req_key_ff;
            values_ff[i] <= req_value_ff;
         end else if (cmd.execute && req_op_ff == OP_SET && hit_ff
                      && hit_idx_ff == IDX_W'(i)) begin
            values_ff[i] <= req_value_ff;
         end
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= evict_ff;
         if (req_op_ff == OP_SET) begin
            rsp_value_ff <= '0;
         end else if (hit_ff) begin
            rsp_value_ff <= values_ff[hit_idx_ff];
         end else begin
            rsp_value_ff <= MISS_VALUE;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.occupancy   = occ_ff;
   assign status.entry_valid = valid_ff;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative 16-entry key-value store with least-recently-used
// replacement and a programmable capacity.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid/ready     operation, key, value
//   rsp_chan  out   valid/ready     hit, read_value, evicted
//   csr_*     in    write enable    capacity (5 bits)
//
// Each item goes through accept, parallel key lookup over all entries,
// then execute into the output register, as sequenced by the controller.
// The next item is accepted while a result still waits in the output
// register; execute stalls only while that register is full and not taken.
// On reset the valid bits, ranks and occupancy clear, and capacity = 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   lkvc_req_if.sink         req_chan,
   lkvc_rsp_if.source       rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   lkvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_chan.operation),
      .req_key          (req_chan.key),
      .req_value        (req_chan.value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_hit          (rsp_chan.hit),
      .rsp_read_value   (rsp_chan.read_value),
      .rsp_evicted      (rsp_chan.evicted)
   );

   // checks
   `ASSERT_ALWAYS(a_occ_bound, clock, reset, status.occupancy <= OCC_W'(ENTRIES))
   `ASSERT_ALWAYS(a_occ_count, clock, reset, $countones(status.entry_valid) == int'(status.occupancy))
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ASSERT_NEXT(a_exec_result, clock, reset, cmd.execute, rsp_chan.valid)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get/set items into the cache through its request channel and checks
// each response against a cycle-free LRU store model kept in the bench. The
// capacity register is swept between phases, including zero, the saturating
// values and a drop below the current occupancy. Both channels idle and
// stall at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import lkvc_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int KEY_POOL     = 24;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      op_type                  op;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } cache_req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
      logic                    evicted;
   } cache_rsp_type;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CAP_W-1:0] csr_write_data;

   lkvc_req_if req_bus ();
   lkvc_rsp_if rsp_bus ();

   lru_key_value_cache i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // items waiting for the driver, and responses still owed by the cache
   cache_req_type pending_items[$];
   cache_rsp_type expected_rsps[$];
   int         items_queued;
   int         rsps_seen;
   int         fail_count;
   int         cycle_count;
   logic       req_taken;
   logic       no_idle;

   // long receiver hold-off
   logic       hold_arm;
   logic       hold_arm_d;
   int         hold_left;

   int         gap_left;
   int         stall_left;

   // model of the store
   logic [KEY_W-1:0]        slot_key[ENTRIES];
   logic signed [VAL_W-1:0] slot_value[ENTRIES];
   logic                    slot_valid[ENTRIES];
   int                      slot_age[ENTRIES];
   int                      used_slots;
   logic [CAP_W-1:0]        capacity_reg;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ages valid entries younger than lim, then makes slot s the newest
   function automatic void promote(int s, int lim);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && i != s && slot_age[i] < lim) slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   function automatic void cache_clear();
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_age[i]   = 0;
      end
      used_slots   = 0;
      capacity_reg = CAP_RESET;
   endfunction

   // applies one item to the store and returns the response it must produce
   function automatic cache_rsp_type cache_apply(cache_req_type item);
      int            found;
      int            eff_cap;
      int            victim;
      int            oldest;
      cache_rsp_type res;
      eff_cap = capacity_reg;
      if (eff_cap < 1) eff_cap = 1;
      if (eff_cap > ENTRIES) eff_cap = ENTRIES;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_valid[i] && slot_key[i] == item.key) found = i;
      end
      res.hit        = (found >= 0);
      res.read_value = '0;
      res.evicted    = 1'b0;
      if (item.op == OP_GET) begin
         if (found >= 0) begin
            res.read_value = slot_value[found];
            promote(found, slot_age[found]);
         end else begin
            res.read_value = MISS_VALUE;
         end
         return res;
      end
      if (found >= 0) begin
         slot_value[found] = item.value;
         promote(found, slot_age[found]);
         return res;
      end
      // insertion: evict the oldest entry once occupancy reaches capacity
      if (used_slots >= eff_cap && used_slots > 0) begin
         victim = -1;
         oldest = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_age[i] > oldest)) begin
               victim = i;
               oldest = slot_age[i];
            end
         end
         if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            slot_age[victim]   = 0;
            used_slots--;
            res.evicted = 1'b1;
         end
      end
      // new key takes the lowest free slot
      for (int i = 0; i < ENTRIES; i++) begin
         if (!slot_valid[i]) begin
            slot_key[i]   = item.key;
            slot_value[i] = item.value;
            slot_valid[i] = 1'b1;
            used_slots++;
            promote(i, ENTRIES);
            break;
         end
      end
      return res;
   endfunction

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // monitor: tracks accepted items, register writes and responses
   always @(posedge clock) begin : monitor
      cache_rsp_type want;
      if (reset) begin
         cache_clear();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (csr_write_enable) capacity_reg = csr_write_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0d: unexpected response: hit=%b value=%h evicted=%b",
                     cycle_count, rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted);
            end else begin
               want = expected_rsps.pop_front();
               rsps_seen++;
               if (rsp_bus.hit !== want.hit || rsp_bus.read_value !== want.read_value ||
                   rsp_bus.evicted !== want.evicted) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0d: rsp %0d exp hit=%b val=%h ev=%b, got hit=%b val=%h ev=%b",
                        cycle_count, rsps_seen, want.hit, want.read_value, want.evicted,
                        rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_rsps.push_back(cache_apply('{op: op_type'(req_bus.operation),
               key: req_bus.key, value: req_bus.value}));
      end
   end

   // request driver with random idle bursts
   always @(negedge clock) begin : driver
      cache_req_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left != 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= $urandom_range(0, 7);
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.operation <= next_item.op;
            req_bus.key       <= next_item.key;
            req_bus.value     <= next_item.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long hold-off counter, started by a rising hold_arm
   always @(negedge clock) begin
      hold_arm_d <= hold_arm;
      if (hold_arm && !hold_arm_d) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // response ready with random stall bursts
   always @(negedge clock) begin
      if (reset || hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // stimulus
   initial begin : stimulus
      logic [KEY_W-1:0] key_pool[KEY_POOL];
      logic [CAP_W-1:0] phase_caps[10];
      int               eff_cap;
      int               span;
      int               pick;
      logic signed [VAL_W-1:0] val;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_GET;
      req_bus.key       = '0;
      req_bus.value     = '0;
      rsp_bus.ready     = 1'b0;
      req_taken   = 1'b0;
      no_idle     = 1'b0;
      hold_arm    = 1'b0;
      hold_arm_d  = 1'b0;
      hold_left   = 0;
      gap_left    = 0;
      stall_left  = 0;
      cycle_count = 0;
      items_queued = 0;
      rsps_seen    = 0;
      fail_count   = 0;
      cache_clear();

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty miss, extreme keys and values, update, fill and evict
      queue_item(OP_GET, 32'h0, 32'sh0);
      queue_item(OP_SET, 32'h0, 32'sh7FFF_FFFF);
      queue_item(OP_GET, 32'h0, 32'sh0);
      queue_item(OP_SET, 32'hFFFF_FFFF, 32'sh8000_0000);
      queue_item(OP_GET, 32'hFFFF_FFFF, 32'sh1234_5678);
      queue_item(OP_SET, 32'h0, -32'sd1);
      queue_item(OP_GET, 32'h0, 32'sh0);
      for (int i = 2; i < ENTRIES; i++) queue_item(OP_SET, key_pool[i], $urandom);
      queue_item(OP_SET, key_pool[ENTRIES], 32'sh0);
      queue_item(OP_GET, 32'hFFFF_FFFF, 32'sh0);
      queue_item(OP_GET, 32'h0, 32'sh0);
      queue_item(OP_GET, key_pool[ENTRIES], 32'sh0);

      // capacity phases: first one drops below the full occupancy
      phase_caps = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd17, 5'd8, 5'd16, 5'd2, 5'd12, 5'd16};
      for (int p = 0; p < 10; p++) begin
         write_capacity(phase_caps[p]);
         eff_cap = phase_caps[p];
         if (eff_cap < 1) eff_cap = 1;
         if (eff_cap > ENTRIES) eff_cap = ENTRIES;
         span = (eff_cap + 4 > KEY_POOL) ? KEY_POOL : eff_cap + 4;
         if (p == 9) no_idle = 1'b1;
         // hold the receiver off for a long stretch at the start of this phase
         if (p == 6) hold_arm <= 1'b1;
         for (int n = 0; n < 62; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
               0: val = 32'sh0;
               1: val = -32'sd1;
               2: val = 32'sh8000_0000;
               3: val = 32'sh7FFF_FFFF;
               default: val = $urandom;
            endcase
            queue_item(op_type'($urandom_range(0, 1)),
               (pick < 80) ? key_pool[$urandom_range(0, span - 1)] :
               (pick < 90) ? key_pool[$urandom_range(0, KEY_POOL - 1)] : $urandom,
               val);
         end
      end

      wait_rsps_done();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   task automatic queue_item(op_type op, logic [KEY_W-1:0] key, logic signed [VAL_W-1:0] value);
      pending_items.push_back('{op: op, key: key, value: value});
      items_queued++;
   endtask

   // sender pause: every queued item has its response back
   task automatic wait_rsps_done();
      while (rsps_seen != items_queued) @(negedge clock);
   endtask

   // register write only with the cache idle
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_rsps_done();
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

endmodule
